FILE: design/pirl_pkg.sv
`timescale 1ns / 1ps

package pirl_pkg;

  localparam int DEPTH_DEF  = 16;
  // a run never shows more than this many entries
  localparam int RESULT_CAP = 16;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // datapath action of one control word
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_SETUP,
    ACT_READ_NEIGH,
    ACT_WRITE_SHIFT,
    ACT_WRITE_VAL,
    ACT_COMMIT,
    ACT_READ_EMIT,
    ACT_LOAD_OK,
    ACT_LOAD_ERR
  } act_t;

  // jump condition of one control word
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_CMD_UNUSED,
    C_BAD_POS,
    C_FULL,
    C_SHIFT_DONE,
    C_REMOVE,
    C_OUT_BUSY,
    C_EMIT_MORE
  } cond_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic cmd_unused;
    logic bad_pos;
    logic full;
    logic shift_done;
    logic is_remove;
    logic out_busy;
    logic emit_more;
  } flags_t;

  // program addresses
  localparam upc_t U_FETCH     = 5'd0;
  localparam upc_t U_CHK_CMD   = 5'd1;
  localparam upc_t U_CHK_POS   = 5'd2;
  localparam upc_t U_CHK_FULL  = 5'd3;
  localparam upc_t U_SETUP     = 5'd4;
  localparam upc_t U_LOOP      = 5'd5;
  localparam upc_t U_SHIFT_WR  = 5'd6;
  localparam upc_t U_AFTER     = 5'd7;
  localparam upc_t U_WRITE_VAL = 5'd8;
  localparam upc_t U_COMMIT    = 5'd9;
  localparam upc_t U_EMIT_RD   = 5'd10;
  localparam upc_t U_EMIT_LD   = 5'd11;
  localparam upc_t U_EMIT_WAIT = 5'd12;
  localparam upc_t U_EMIT_NEXT = 5'd13;
  localparam upc_t U_DONE      = 5'd14;
  localparam upc_t U_ERR       = 5'd15;
  localparam upc_t U_ERR_WAIT  = 5'd16;
  localparam upc_t U_ERR_DONE  = 5'd17;

  // control store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = '{act: ACT_NOP, cond: C_ALWAYS, target: U_FETCH};
    case (a)
      U_FETCH:     w = '{act: ACT_ACCEPT,      cond: C_NO_INPUT,   target: U_FETCH};
      U_CHK_CMD:   w = '{act: ACT_NOP,         cond: C_CMD_UNUSED, target: U_FETCH};
      U_CHK_POS:   w = '{act: ACT_NOP,         cond: C_BAD_POS,    target: U_ERR};
      U_CHK_FULL:  w = '{act: ACT_NOP,         cond: C_FULL,       target: U_ERR};
      U_SETUP:     w = '{act: ACT_SETUP,       cond: C_NEXT,       target: U_FETCH};
      U_LOOP:      w = '{act: ACT_READ_NEIGH,  cond: C_SHIFT_DONE, target: U_AFTER};
      U_SHIFT_WR:  w = '{act: ACT_WRITE_SHIFT, cond: C_ALWAYS,     target: U_LOOP};
      U_AFTER:     w = '{act: ACT_NOP,         cond: C_REMOVE,     target: U_COMMIT};
      U_WRITE_VAL: w = '{act: ACT_WRITE_VAL,   cond: C_NEXT,       target: U_FETCH};
      U_COMMIT:    w = '{act: ACT_COMMIT,      cond: C_NEXT,       target: U_FETCH};
      U_EMIT_RD:   w = '{act: ACT_READ_EMIT,   cond: C_NEXT,       target: U_FETCH};
      U_EMIT_LD:   w = '{act: ACT_LOAD_OK,     cond: C_NEXT,       target: U_FETCH};
      U_EMIT_WAIT: w = '{act: ACT_NOP,         cond: C_OUT_BUSY,   target: U_EMIT_WAIT};
      U_EMIT_NEXT: w = '{act: ACT_NOP,         cond: C_EMIT_MORE,  target: U_EMIT_RD};
      U_DONE:      w = '{act: ACT_NOP,         cond: C_ALWAYS,     target: U_FETCH};
      U_ERR:       w = '{act: ACT_LOAD_ERR,    cond: C_NEXT,       target: U_FETCH};
      U_ERR_WAIT:  w = '{act: ACT_NOP,         cond: C_OUT_BUSY,   target: U_ERR_WAIT};
      U_ERR_DONE:  w = '{act: ACT_NOP,         cond: C_ALWAYS,     target: U_FETCH};
      default:     w = '{act: ACT_NOP,         cond: C_ALWAYS,     target: U_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: design/pirl_sequencer.sv
`timescale 1ns / 1ps

module pirl_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  pirl_pkg::flags_t flags,
  output pirl_pkg::act_t   act
);
  import pirl_pkg::*;

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   taken;

  assign uw  = ucode(upc);
  assign act = uw.act;

  always_comb begin
    unique case (uw.cond)
      C_NEXT:       taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_INPUT:   taken = !flags.in_valid;
      C_CMD_UNUSED: taken = flags.cmd_unused;
      C_BAD_POS:    taken = flags.bad_pos;
      C_FULL:       taken = flags.full;
      C_SHIFT_DONE: taken = flags.shift_done;
      C_REMOVE:     taken = flags.is_remove;
      C_OUT_BUSY:   taken = flags.out_busy;
      C_EMIT_MORE:  taken = flags.emit_more;
      default:      taken = 1'b1;
    endcase
    upc_next = taken ? uw.target : upc + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: design/pirl_datapath.sv
`timescale 1ns / 1ps

module pirl_datapath #(
  parameter int DEPTH = pirl_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pirl_pkg::act_t                      act,
  output pirl_pkg::flags_t                    flags,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pirl_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pirl_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);
  import pirl_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [CW-1:0] raddr;

  logic [1:0]    cmd;
  logic [3:0]    pos;
  logic [31:0]   val;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] eidx;
  logic [CW-1:0] eidx_inc;
  logic          is_app, is_ins, is_rem;
  logic          emit_last;

  logic          out_valid;
  logic [1:0]    out_status;
  logic [3:0]    out_index;
  logic [31:0]   out_value;
  logic [4:0]    out_count;
  logic          out_last;

  assign is_app = (cmd == CMD_APPEND);
  assign is_ins = (cmd == CMD_INSERT);
  assign is_rem = (cmd == CMD_REMOVE);

  assign s_tready = (act == ACT_ACCEPT);

  assign flags.in_valid   = s_tvalid;
  assign flags.cmd_unused = !(is_app || is_ins || is_rem);
  assign flags.bad_pos    = (is_ins || is_rem) &&
                            ((pos == 4'd0) || (CMPW'(pos) >= CMPW'(count)));
  assign flags.full       = (is_app || is_ins) && (count == CW'(DEPTH));
  assign flags.shift_done = is_app ||
                            (is_ins && (ptr == CW'(pos))) ||
                            (is_rem && ((ptr + CW'(1)) >= count));
  assign flags.is_remove  = is_rem;
  assign flags.out_busy   = out_valid;
  assign flags.emit_more  = !out_last;

  // memory ports
  assign we    = (act == ACT_WRITE_SHIFT) || (act == ACT_WRITE_VAL);
  assign waddr = ptr[AW-1:0];
  assign wdata = (act == ACT_WRITE_VAL) ? val : rdata;

  always_comb begin
    if (act == ACT_READ_EMIT) begin
      raddr = eidx;
    end else if (is_ins) begin
      raddr = ptr - CW'(1);
    end else begin
      raddr = ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr[AW-1:0]];
  end

  assign eidx_inc  = eidx + CW'(1);
  assign emit_last = (eidx_inc == count) ||
                     ((DEPTH > RESULT_CAP) && (eidx_inc == CW'(RESULT_CAP)));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (act)
        ACT_ACCEPT: begin
          if (s_tvalid) begin
            cmd <= s_tdata[1:0];
            pos <= s_tdata[5:2];
            val <= s_tdata[37:6];
          end
        end
        ACT_SETUP:       ptr <= is_rem ? CW'(pos) : count;
        ACT_WRITE_SHIFT: ptr <= is_ins ? ptr - CW'(1) : ptr + CW'(1);
        ACT_COMMIT: begin
          count <= is_rem ? count - CW'(1) : count + CW'(1);
          eidx  <= '0;
        end
        ACT_LOAD_OK: begin
          out_valid  <= 1'b1;
          out_status <= STAT_OK;
          out_index  <= 4'(eidx);
          out_value  <= rdata;
          out_count  <= 5'(count);
          out_last   <= emit_last;
          eidx       <= eidx_inc;
        end
        ACT_LOAD_ERR: begin
          out_valid  <= 1'b1;
          out_status <= flags.bad_pos ? STAT_BAD_POS : STAT_FULL;
          out_index  <= '0;
          out_value  <= '0;
          out_count  <= 5'(count);
          out_last   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'd0, out_count, out_value, out_index, out_status};

  a_ready_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !out_valid)
    else $error("input taken while a result is still pending");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on consecutive cycles");

  a_error_is_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != STAT_OK)) |-> (out_last && (out_index == 4'd0)))
    else $error("error result not a single final transfer");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (ptr < CW'(DEPTH)))
    else $error("entry write beyond depth");

endmodule

FILE: design/positional_insert_remove_list.sv
`timescale 1ns / 1ps

// positional insert / remove list
//
// holds an ordered list of up to DEPTH signed 32-bit entries. one command
// arrives per input transfer on the s_ side: append at the end, insert at a
// position (later entries move up) or remove at a position (later entries
// move down). positions from 1 to count-1 are legal for insert and remove.
// after a good command the whole list (at most 16 entries) leaves on the m_
// side, one transfer per entry in index order, tlast on the final one. a
// rejected command gives one transfer with a non-zero status and tlast set.
// command code 3 is dropped without any result.
//
// a small program in a control store steps an entry memory with separate
// write and read ports: each moved entry is read from its neighbour and then
// written in its new place, and each emitted entry is read, loaded into the
// result register and held until the receiver takes it, after which the
// program checks for more. s_tready is high only while the sequencer waits
// for a command, so one item is in work at a time. a stalled receiver holds
// the result register and the program waits.
// reset empties the list (count 0) and drops any pending result; entry
// contents are not cleared, and no value above the count is ever used.
module positional_insert_remove_list #(
  parameter int DEPTH = pirl_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // command [1:0], position [5:2], value [37:6], zero pad [39:38]
  input  logic [pirl_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status [1:0], entry_index [5:2], entry_value [37:6], count [42:38],
  // zero pad [47:43]
  output logic [pirl_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import pirl_pkg::*;

  act_t   act;
  flags_t flags;

  // control store and step counter
  pirl_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .act   (act)
  );

  // entry memory, pointers, count and the result register
  pirl_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .act      (act),
    .flags    (flags),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
